### sv/ntc_pkg.sv
// ============================================================================
// ntc_pkg: shared types, constants and tables of the NTC linearizer
// Holds the resistance/temperature table, datapath widths, the result record
// and the request/response records of the shared add/subtract unit.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ntc_pkg;

  // Converter and table geometry.
  localparam int ADC_BITS      = 12;
  localparam int TABLE_ENTRIES = 37;
  localparam int IDX_W         = 6;

  // Field widths.
  localparam int SER_W  = 20;
  localparam int RES_W  = 24;
  localparam int TEMP_W = 15;

  // Stream widths, padded to whole bytes.
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 48;

  // Datapath widths.
  localparam int ALU_W   = 32;
  localparam int NUM_W   = 36;
  localparam int REM_W   = 23;
  localparam int CNT_W   = 5;
  localparam int MULA_W  = 24;
  localparam int MULB_W  = 16;
  localparam int MULP_W  = MULA_W + MULB_W;

  // Quotient lengths of the two divisions.
  localparam int DIV1_STEPS = 24;
  localparam int DIV2_STEPS = 9;

  localparam logic [ADC_BITS-1:0] ADC_MAX = ADC_BITS'((1 << ADC_BITS) - 1);
  localparam logic [SER_W-1:0]    SER_RESET = SER_W'(10000);
  localparam logic [RES_W-1:0]    RES_SAT = RES_W'((1 << RES_W) - 1);

  localparam int TEMP_STEP_INT = 500;
  localparam int TEMP_COLD_INT = -5500;
  localparam int TEMP_HOT_INT  = 12500;
  localparam logic signed [TEMP_W-1:0] TEMP_COLD = TEMP_W'(TEMP_COLD_INT);
  localparam logic signed [TEMP_W-1:0] TEMP_HOT  = TEMP_W'(TEMP_HOT_INT);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [IDX_W-1:0] IDX_END  = IDX_W'(TABLE_ENTRIES);

  typedef enum logic [1:0] {
    RANGE_IN   = 2'd0,
    RANGE_COLD = 2'd1,
    RANGE_HOT  = 2'd2
  } range_e;

  // Result record; temp sits in the low bits so it packs straight into tdata.
  typedef struct packed {
    range_e                    status;
    logic [RES_W-1:0]          res;
    logic signed [TEMP_W-1:0]  temp;
  } ntc_res_t;

  typedef enum logic {
    ALU_SUB = 1'b0,
    ALU_ADD = 1'b1
  } alu_op_e;

  typedef struct packed {
    alu_op_e            op;
    logic [ALU_W-1:0]   a;
    logic [ALU_W-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0]   y;
    logic               ge;
  } alu_rsp_t;

  // Thermistor resistance in tenths of an ohm, one entry per 5 degC step
  // from -55 degC upward, strictly descending.
  function automatic logic [RES_W-1:0] res_of(input logic [IDX_W-1:0] idx);
    logic [RES_W-1:0] r;
    case (idx)
      6'd0:    r = 24'd12146000;
      6'd1:    r = 24'd8443900;
      6'd2:    r = 24'd5924300;
      6'd3:    r = 24'd4193800;
      6'd4:    r = 24'd2994800;
      6'd5:    r = 24'd2156700;
      6'd6:    r = 24'd1564100;
      6'd7:    r = 24'd1146600;
      6'd8:    r = 24'd845100;
      6'd9:    r = 24'd629270;
      6'd10:   r = 24'd470770;
      6'd11:   r = 24'd355630;
      6'd12:   r = 24'd271190;
      6'd13:   r = 24'd208600;
      6'd14:   r = 24'd162040;
      6'd15:   r = 24'd126830;
      6'd16:   r = 24'd100000;
      6'd17:   r = 24'd79420;
      6'd18:   r = 24'd63270;
      6'd19:   r = 24'd50740;
      6'd20:   r = 24'd41030;
      6'd21:   r = 24'd33360;
      6'd22:   r = 24'd27240;
      6'd23:   r = 24'd22370;
      6'd24:   r = 24'd18460;
      6'd25:   r = 24'd15300;
      6'd26:   r = 24'd12750;
      6'd27:   r = 24'd10680;
      6'd28:   r = 24'd8993;
      6'd29:   r = 24'd7607;
      6'd30:   r = 24'd6452;
      6'd31:   r = 24'd5494;
      6'd32:   r = 24'd4700;
      6'd33:   r = 24'd4036;
      6'd34:   r = 24'd3474;
      6'd35:   r = 24'd3001;
      6'd36:   r = 24'd2601;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Table temperature in hundredths of a degree for an entry.
  function automatic logic signed [TEMP_W-1:0] temp_of(input logic [IDX_W-1:0] idx);
    return TEMP_W'(TEMP_COLD_INT + TEMP_STEP_INT * int'(idx));
  endfunction

endpackage

`default_nettype wire

### sv/ntc_thermistor_linearizer.sv
// ============================================================================
// ntc_thermistor_linearizer: 10K NTC divider reading to resistance and temperature
// Computes the thermistor resistance from a 12-bit converter sample, looks it
// up in a 37-point table and interpolates to hundredths of a degree Celsius.
// ============================================================================
//
//  Channel   Direction  Handshake                     Payload
//  s_axis    in         s_axis_tvalid / s_axis_tready tdata[11:0] adc_sample
//  m_axis    out        m_axis_tvalid / m_axis_tready tdata[14:0] temperature_centi,
//                                                     [38:15] resistance_deci,
//                                                     [40:39] range_status
//  cfg       in         cfg_valid_i / cfg_ready_o     cfg_data_i series_resistor
//
//  The block takes the next sample only once the previous result has moved into
//  the output register. The work runs bit-serially through the single shared
//  adder: 24 quotient bits for the resistance, up to six bisection probes of the
//  table and 9 quotient bits for the interpolation offset. A full-scale sample
//  skips the multiply, the division and the search; a saturated resistance skips
//  the division and the search. Reset loads the series resistor with 10000 ohms
//  and empties the output register. A stalled output holds its result while the
//  next sample is already taken; only the handoff of a second result waits for
//  the first transfer to finish.
//
`timescale 1ns / 1ps
`default_nettype none

module ntc_thermistor_linearizer import ntc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // [11:0] adc_sample, [15:12] zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [14:0] temperature_centi, [38:15] resistance_deci, [40:39] range_status,
  // [47:41] zero
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [SER_W-1:0]     cfg_data_i
);

  logic [SER_W-1:0] series_q;
  logic             out_valid_q;
  ntc_res_t         out_q;

  logic             core_ready;
  logic             core_done;
  logic             out_free;
  ntc_res_t         core_res;

  // The output register is free when empty or when its result leaves now.
  assign out_free = !out_valid_q || m_axis_tready;

  ntc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (s_axis_tvalid),
    .sample_i (s_axis_tdata[ADC_BITS-1:0]),
    .series_i (series_q),
    .ready_o  (core_ready),
    .done_o   (core_done),
    .take_i   (out_free),
    .res_o    (core_res)
  );

  assign s_axis_tready = core_ready;

  // The series resistor is written only while no sample is in flight: the core
  // must be idle and no sample may be offered in the same cycle, so a write
  // never lands between a sample transfer and the multiply that reads it.
  assign cfg_ready_o = core_ready && !s_axis_tvalid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      series_q <= SER_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      series_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_done && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_done && out_free) begin
      out_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W-$bits(ntc_res_t)){1'b0}}, out_q};

  a_cold_temp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == RANGE_COLD) |-> (out_q.temp == TEMP_COLD))
    else $error("cold status without the coldest temperature");

  a_hot_temp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == RANGE_HOT) |-> (out_q.temp == TEMP_HOT))
    else $error("hot status without the hottest temperature");

  a_in_range_temp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == RANGE_IN)
      |-> (out_q.temp >= TEMP_COLD && out_q.temp <= TEMP_HOT))
    else $error("interpolated temperature outside the table span");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.status == RANGE_IN || out_q.status == RANGE_COLD
                     || out_q.status == RANGE_HOT))
    else $error("undefined range status on output");

endmodule

`default_nettype wire

### sv/ntc_alu.sv
// ============================================================================
// ntc_alu: shared add/subtract and compare unit
// One 32-bit adder serves every division step, table compare and correction.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ntc_alu import ntc_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic             is_sub;
  logic [ALU_W-1:0] b_eff;
  logic [ALU_W:0]   sum;

  assign is_sub = (req_i.op == ALU_SUB);
  assign b_eff  = is_sub ? ~req_i.b : req_i.b;
  assign sum    = {1'b0, req_i.a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, is_sub};

  // For a subtraction the carry out is set exactly when a >= b.
  assign rsp_o.y  = sum[ALU_W-1:0];
  assign rsp_o.ge = sum[ALU_W];

endmodule

`default_nettype wire

### sv/ntc_core.sv
// ============================================================================
// ntc_core: sequencer and datapath of the NTC linearizer
// Multiplies, divides bit by bit, searches the table by bisection and
// interpolates, all through one shared add/subtract unit.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ntc_core import ntc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [ADC_BITS-1:0] sample_i,
  input  logic [SER_W-1:0]    series_i,
  output logic                ready_o,
  output logic                done_o,
  input  logic                take_i,
  output ntc_res_t            res_o
);

  typedef enum logic [11:0] {
    ST_IDLE   = 12'h001,
    ST_MUL    = 12'h002,
    ST_SAT    = 12'h004,
    ST_DIV    = 12'h008,
    ST_SEARCH = 12'h010,
    ST_CLASS  = 12'h020,
    ST_DIFF   = 12'h040,
    ST_MUL2   = 12'h080,
    ST_ADD    = 12'h100,
    ST_DIV2   = 12'h200,
    ST_TEMP   = 12'h400,
    ST_DONE   = 12'h800
  } state_e;

  state_e              state_q, state_d;
  logic [ADC_BITS-1:0] adc_q, adc_d;
  logic [RES_W-1:0]    den_q, den_d;
  logic [NUM_W-1:0]    num_q, num_d;
  logic [REM_W-1:0]    rem_q, rem_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [IDX_W-1:0]    lo_q, lo_d;
  logic [IDX_W-1:0]    hi_q, hi_d;
  ntc_res_t            res_q, res_d;

  logic [REM_W:0]      trial;
  logic [IDX_W:0]      mid_sum;
  logic [IDX_W-1:0]    mid;
  logic [IDX_W-1:0]    idx_prev;
  logic [MULB_W-1:0]   adc_x10;
  logic [MULA_W-1:0]   mul_a;
  logic [MULB_W-1:0]   mul_b;
  logic [MULP_W-1:0]   product;
  logic [TEMP_W-1:0]   temp_tab;
  alu_req_t            alu_req;
  alu_rsp_t            alu_rsp;

  ntc_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Restoring division: next dividend bit enters below the partial remainder.
  assign trial    = {rem_q, num_q[NUM_W-1]};
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = mid_sum[IDX_W:1];
  assign idx_prev = lo_q - 1'b1;
  assign temp_tab = temp_of(lo_q);

  assign adc_x10 = ({{(MULB_W-ADC_BITS){1'b0}}, adc_q} << 3)
                 + ({{(MULB_W-ADC_BITS){1'b0}}, adc_q} << 1);

  always_comb begin
    if (state_q == ST_MUL2) begin
      mul_a = {{(MULA_W-REM_W){1'b0}}, rem_q};
      mul_b = MULB_W'(TEMP_STEP_INT);
    end else begin
      mul_a = {{(MULA_W-SER_W){1'b0}}, series_i};
      mul_b = adc_x10;
    end
  end

  assign product = MULP_W'(mul_a) * MULP_W'(mul_b);

  // Operand selection for the shared unit.
  always_comb begin
    alu_req.op = ALU_SUB;
    alu_req.a  = '0;
    alu_req.b  = '0;
    case (state_q)
      ST_SAT: begin
        alu_req.a = ALU_W'(num_q[NUM_W-1 -: ADC_BITS]);
        alu_req.b = ALU_W'(den_q);
      end
      ST_DIV, ST_DIV2: begin
        alu_req.a = ALU_W'(trial);
        alu_req.b = ALU_W'(den_q);
      end
      ST_SEARCH: begin
        alu_req.a = ALU_W'(res_of(mid));
        alu_req.b = ALU_W'(res_q.res);
      end
      ST_CLASS: begin
        if (lo_q == IDX_END) begin
          alu_req.a = ALU_W'(res_q.res);
          alu_req.b = ALU_W'(res_of(IDX_LAST));
        end else begin
          alu_req.a = ALU_W'(res_of(idx_prev));
          alu_req.b = ALU_W'(res_of(lo_q));
        end
      end
      ST_DIFF: begin
        alu_req.a = ALU_W'(res_q.res);
        alu_req.b = ALU_W'(res_of(lo_q));
      end
      ST_ADD: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = ALU_W'(num_q[ALU_W-1:0]);
        alu_req.b  = ALU_W'(den_q >> 1);
      end
      ST_TEMP: begin
        alu_req.a = {{(ALU_W-TEMP_W){temp_tab[TEMP_W-1]}}, temp_tab};
        alu_req.b = ALU_W'(num_q[DIV2_STEPS-1:0]);
      end
      default: begin
        alu_req.op = ALU_SUB;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    adc_d   = adc_q;
    den_d   = den_q;
    num_d   = num_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    res_d   = res_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          adc_d = sample_i;
          den_d = {{(RES_W-ADC_BITS){1'b0}}, ~sample_i};
          if (sample_i == ADC_MAX) begin
            res_d.res    = RES_SAT;
            res_d.temp   = TEMP_COLD;
            res_d.status = RANGE_COLD;
            state_d      = ST_DONE;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        num_d   = product[NUM_W-1:0];
        state_d = ST_SAT;
      end
      ST_SAT: begin
        // A quotient of 2^24 or more shows up as a top slice not below the divisor.
        if (alu_rsp.ge) begin
          res_d.res    = RES_SAT;
          res_d.temp   = TEMP_COLD;
          res_d.status = RANGE_COLD;
          state_d      = ST_DONE;
        end else begin
          rem_d   = {{(REM_W-ADC_BITS){1'b0}}, num_q[NUM_W-1 -: ADC_BITS]};
          num_d   = {num_q[NUM_W-ADC_BITS-1:0], {ADC_BITS{1'b0}}};
          cnt_d   = CNT_W'(DIV1_STEPS - 1);
          state_d = ST_DIV;
        end
      end
      ST_DIV, ST_DIV2: begin
        rem_d = alu_rsp.ge ? alu_rsp.y[REM_W-1:0] : trial[REM_W-1:0];
        num_d = {num_q[NUM_W-2:0], alu_rsp.ge};
        if (cnt_q == '0) begin
          if (state_q == ST_DIV) begin
            res_d.res = {num_q[RES_W-2:0], alu_rsp.ge};
            lo_d      = '0;
            hi_d      = IDX_END;
            state_d   = ST_SEARCH;
          end else begin
            state_d = ST_TEMP;
          end
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_SEARCH: begin
        // Bisection for the first entry strictly below the resistance.
        if (lo_q == hi_q) begin
          state_d = ST_CLASS;
        end else if (!alu_rsp.ge) begin
          hi_d = mid;
        end else begin
          lo_d = mid + 1'b1;
        end
      end
      ST_CLASS: begin
        if (lo_q == '0) begin
          res_d.temp   = TEMP_COLD;
          res_d.status = RANGE_COLD;
          state_d      = ST_DONE;
        end else if (lo_q == IDX_END) begin
          // Not above the last entry: in range only when exactly equal to it.
          res_d.temp   = TEMP_HOT;
          res_d.status = alu_rsp.ge ? RANGE_IN : RANGE_HOT;
          state_d      = ST_DONE;
        end else begin
          den_d   = alu_rsp.y[RES_W-1:0];
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        rem_d   = alu_rsp.y[REM_W-1:0];
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        num_d   = product[NUM_W-1:0];
        state_d = ST_ADD;
      end
      ST_ADD: begin
        // The offset is below 512, so the top slice is already below the divisor.
        rem_d   = alu_rsp.y[ALU_W-1:DIV2_STEPS];
        num_d   = {alu_rsp.y[DIV2_STEPS-1:0], {(NUM_W-DIV2_STEPS){1'b0}}};
        cnt_d   = CNT_W'(DIV2_STEPS - 1);
        state_d = ST_DIV2;
      end
      ST_TEMP: begin
        res_d.temp   = alu_rsp.y[TEMP_W-1:0];
        res_d.status = RANGE_IN;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    adc_q <= adc_d;
    den_q <= den_d;
    num_q <= num_d;
    rem_q <= rem_d;
    res_q <= res_d;
  end

  assign ready_o = (state_q == ST_IDLE);
  assign done_o  = (state_q == ST_DONE);
  assign res_o   = res_q;

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV || state_q == ST_DIV2) |-> ({1'b0, rem_q} < den_q))
    else $error("partial remainder not below divisor");

  a_search_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> (lo_q <= hi_q && hi_q <= IDX_END))
    else $error("bisection bounds out of order");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ready_o && start_i) |=> !ready_o)
    else $error("core still ready after taking a sample");

endmodule

`default_nettype wire

### sim/ntc_thermistor_linearizer_tb.sv
// ============================================================================
// ntc_thermistor_linearizer_tb: self-checking bench for the NTC linearizer
// A table of directed samples, then about 1700 random samples over several
// series resistor settings. Every result transfer is compared with an expected
// resistance, temperature and range: a software prediction, or a typed row's own
// result. Random stalls are applied on the sample and result streams.
// ============================================================================
`timescale 1ns / 1ps

module ntc_thermistor_linearizer_tb;
  import ntc_pkg::*;

  typedef longint unsigned u64_t;

  localparam int HALF_PERIOD_NS  = 6;
  localparam int RESET_CYCLES    = 8;
  // Covers the slowest sample with margin.
  localparam int SETTLE_CYCLES   = 60;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASES          = 8;
  localparam int PHASE_SAMPLES   = 210;
  localparam int MAX_PRINTS      = 60;
  // Several times the slowest legal run, including every stall and gap.
  localparam longint RUN_LIMIT_NS = 64'd40_000_000;

  // One directed stimulus row. A typed row carries its own expected result;
  // the others are checked against the predictor.
  typedef struct packed {
    logic [SER_W-1:0]    ohms;
    logic [ADC_BITS-1:0] adc;
    logic                typed;
    ntc_res_t            want;
  } probe_t;

  // One expected result, tagged with the number of the sample that caused it.
  typedef struct packed {
    int unsigned tag;
    ntc_res_t    r;
  } reading_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [SER_W-1:0]     cfg_data_i = '0;

  // Thermistor resistance table in tenths of an ohm, -55 degC upward in
  // 5 degC steps.
  u64_t therm_res_deci [TABLE_ENTRIES] = '{
    12146000, 8443900, 5924300, 4193800, 2994800,
    2156700, 1564100, 1146600, 845100, 629270,
    470770, 355630, 271190, 208600, 162040,
    126830, 100000, 79420, 63270, 50740,
    41030, 33360, 27240, 22370, 18460,
    15300, 12750, 10680, 8993, 7607,
    6452, 5494, 4700, 4036, 3474,
    3001, 2601
  };

  logic [SER_W-1:0] series_ohms = SER_RESET;  // bench copy of the register
  reading_t         pending_readings[$];
  probe_t           probes[$];
  int unsigned      samples_sent = 0;
  int unsigned      mismatch_count = 0;
  bit               idle_free = 1'b0;         // no stalls on either side
  bit               hold_off_pending = 1'b0;  // ask the sink for a long stall
  ntc_res_t         got_reading;
  reading_t         due_reading;

  ntc_thermistor_linearizer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #HALF_PERIOD_NS clk_i = 1'b1;
    #HALF_PERIOD_NS clk_i = 1'b0;
  end

  // Predicts the result for one sample under a given series resistor.
  function automatic ntc_res_t linearize(input logic [ADC_BITS-1:0] adc,
                                         input logic [SER_W-1:0] ohms);
    u64_t     r;
    u64_t     span;
    u64_t     num;
    u64_t     off;
    int       k;
    ntc_res_t o;
    o.res    = RES_SAT;
    o.temp   = TEMP_COLD;
    o.status = RANGE_COLD;
    // Full scale would divide by zero: report it as colder than the table.
    if (adc == ADC_MAX) return o;
    r = (u64_t'(ohms) * 64'd10 * u64_t'(adc)) / u64_t'(ADC_MAX - adc);
    if (r > u64_t'(RES_SAT)) r = u64_t'(RES_SAT);
    o.res = RES_W'(r);
    // First entry strictly below the resistance.
    k = 0;
    while (k < TABLE_ENTRIES && r <= therm_res_deci[k]) k++;
    if (k == 0) begin
      o.temp   = TEMP_COLD;
      o.status = RANGE_COLD;
    end else if (k == TABLE_ENTRIES) begin
      // Landing exactly on the last entry still counts as in range.
      o.temp = TEMP_HOT;
      if (r == therm_res_deci[TABLE_ENTRIES-1]) o.status = RANGE_IN;
      else o.status = RANGE_HOT;
    end else begin
      // Round half up of the offset from the warmer entry.
      span = therm_res_deci[k-1] - therm_res_deci[k];
      num  = (r - therm_res_deci[k]) * u64_t'(TEMP_STEP_INT);
      off  = (num + span / 2) / span;
      if (off > u64_t'(TEMP_STEP_INT)) off = u64_t'(TEMP_STEP_INT);
      o.temp   = TEMP_W'(TEMP_COLD_INT + TEMP_STEP_INT * k - int'(off));
      o.status = RANGE_IN;
    end
    return o;
  endfunction

  task automatic report_mismatch(input string what, input longint want_v,
                                 input longint got_v);
    if (mismatch_count < MAX_PRINTS)
      $display("[%0t] MISMATCH %s: expected %0d, got %0d", $time, what, want_v, got_v);
    mismatch_count++;
  endtask

  function automatic void add_probe(input int unsigned ohms, input int unsigned adc,
                                    input bit typed = 1'b0, input int want_temp = 0,
                                    input int unsigned want_res = 0,
                                    input range_e want_status = RANGE_IN);
    probe_t p;
    p.ohms        = SER_W'(ohms);
    p.adc         = ADC_BITS'(adc);
    p.typed       = typed;
    p.want.temp   = TEMP_W'(want_temp);
    p.want.res    = RES_W'(want_res);
    p.want.status = want_status;
    probes.push_back(p);
  endfunction

  // Offers one sample, after an optional gap, and records what it should give.
  // Entered and left at a falling edge; tvalid stays high for a following
  // back-to-back sample.
  task automatic send_sample(input logic [ADC_BITS-1:0] adc, input int unsigned gap,
                             input bit typed, input ntc_res_t want);
    reading_t e;
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = S_TDATA_W'(adc);
    forever begin
      @(posedge clk_i);
      if (s_axis_tready) break;
    end
    e.tag = samples_sent;
    e.r   = typed ? want : linearize(adc, series_ohms);
    pending_readings.push_back(e);
    samples_sent++;
    @(negedge clk_i);
  endtask

  // Stops offering samples and waits until every expected result is in.
  task automatic wait_for_readings();
    int unsigned guard;
    guard = 0;
    s_axis_tvalid = 1'b0;
    while (pending_readings.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    while (pending_readings.size() != 0) begin
      due_reading = pending_readings.pop_front();
      report_mismatch($sformatf("sample %0d never produced a result", due_reading.tag),
                      0, 1);
    end
    @(negedge clk_i);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_series_resistor(input logic [SER_W-1:0] ohms);
    wait_for_readings();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = ohms;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    series_ohms = ohms;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Result sink: random stalls, mostly short with a few long ones, plus a
  // long hold-off on request that lets the block back up into its input.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned roll;
    stall_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        m_axis_tready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        m_axis_tready = 1'b1;
      end else if (!idle_free && stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 65) stall_left = 0;
        else if (roll < 95) stall_left = $urandom_range(1, 8);
        else stall_left = $urandom_range(20, 150);
      end
    end
  end

  // Result checker: every transfer is matched against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_reading = ntc_res_t'(m_axis_tdata[$bits(ntc_res_t)-1:0]);
      if (pending_readings.size() == 0) begin
        report_mismatch("result transfer with no sample outstanding", 0, 1);
      end else begin
        due_reading = pending_readings.pop_front();
        if (got_reading.temp !== due_reading.r.temp)
          report_mismatch($sformatf("sample %0d temperature_centi", due_reading.tag),
                          due_reading.r.temp, got_reading.temp);
        if (got_reading.res !== due_reading.r.res)
          report_mismatch($sformatf("sample %0d resistance_deci", due_reading.tag),
                          due_reading.r.res, got_reading.res);
        if (got_reading.status !== due_reading.r.status)
          report_mismatch($sformatf("sample %0d range_status", due_reading.tag),
                          due_reading.r.status, got_reading.status);
      end
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    probe_t      p;
    ntc_res_t    none;
    int unsigned gap;
    int unsigned roll;
    int unsigned burst_left;
    int          k;
    int          a;
    u64_t        guess;
    logic [SER_W-1:0]    ohms;
    logic [ADC_BITS-1:0] adc;

    none = '0;
    burst_left = 0;

    // Directed rows. The first ones run with the reset value of the resistor.
    // Full scale, zero and a saturated resistance can be read off directly.
    add_probe(10000, ADC_MAX, 1, TEMP_COLD_INT, RES_SAT, RANGE_COLD);
    add_probe(10000, 0, 1, TEMP_HOT_INT, 0, RANGE_HOT);
    add_probe(10000, ADC_MAX - 1, 1, TEMP_COLD_INT, RES_SAT, RANGE_COLD);
    add_probe(10000, 1);
    add_probe(10000, 2048);
    add_probe(10000, 2047);
    add_probe(10000, 12'h555);
    add_probe(10000, 12'hAAA);
    add_probe(10000, 500);
    add_probe(10000, 3900);
    // 532300 ohms at a reading of 2 lands exactly on the last table entry.
    add_probe(532300, 2, 1, TEMP_HOT_INT, 2601, RANGE_IN);
    add_probe(532300, 3);
    // A zero resistor gives zero resistance, hotter than the table.
    add_probe(0, 2000, 1, TEMP_HOT_INT, 0, RANGE_HOT);
    add_probe(0, ADC_MAX, 1, TEMP_COLD_INT, RES_SAT, RANGE_COLD);
    add_probe(100, 4000);
    add_probe(100, ADC_MAX - 1);
    add_probe(1000000, 1);
    add_probe(1000000, 2048);
    // Just above the coldest entry without saturating.
    add_probe(1000000, 2246);
    add_probe(1000000, 2600);
    add_probe(20'hFFFFF, 2000);
    add_probe(20'hFFFFF, ADC_MAX);
    add_probe(10000, 12'hFFE);

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (probes[i]) begin
      p = probes[i];
      if (p.ohms != series_ohms) write_series_resistor(p.ohms);
      send_sample(p.adc, $urandom_range(0, 3), p.typed, p.typed ? p.want : none);
    end

    // Random phases, each under its own series resistor.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       ohms = SER_W'(1000000);
        1:       ohms = SER_RESET;
        2:       ohms = SER_W'(100);
        3:       ohms = '1;
        7:       ohms = SER_W'($urandom_range(0, (1 << SER_W) - 1));
        default: ohms = SER_W'($urandom_range(100, 1000000));
      endcase
      write_series_resistor(ohms);
      idle_free = (phase == 4 || phase == 6);

      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        // Phase 1 opens with a long sink hold-off under back-to-back samples,
        // so the block fills up and stalls its input.
        if (phase == 1 && n == 0) begin
          hold_off_pending = 1'b1;
          burst_left = 40;
        end
        // Later in the same phase the source pauses until all results are in.
        if (phase == 1 && n == 120) wait_for_readings();

        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          adc = ADC_BITS'($urandom_range(0, ADC_MAX));
        end else if (roll < 80) begin
          case ($urandom_range(0, 3))
            0:       adc = '0;
            1:       adc = ADC_BITS'(1);
            2:       adc = ADC_MAX - 1;
            default: adc = ADC_MAX;
          endcase
        end else begin
          // Aim near a table entry to exercise the search boundaries.
          k = $urandom_range(0, TABLE_ENTRIES - 1);
          guess = (u64_t'(ADC_MAX) * therm_res_deci[k]) /
                  (therm_res_deci[k] + u64_t'(series_ohms) * 64'd10);
          a = int'(guess) + int'($urandom_range(0, 2)) - 1;
          if (a < 0) a = 0;
          if (a > int'(ADC_MAX)) a = int'(ADC_MAX);
          adc = ADC_BITS'(a);
        end

        if (idle_free || burst_left > 0) begin
          gap = 0;
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 60) gap = 0;
          else if (roll < 93) gap = $urandom_range(1, 6);
          else gap = $urandom_range(30, 120);
        end
        if (burst_left > 0) burst_left--;
        send_sample(adc, gap, 1'b0, none);
      end
    end

    idle_free = 1'b0;
    wait_for_readings();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
